### src/rws_pkg.sv
// Shared constants, codes and types of the roulette wheel selector.
// No dependencies; every other file of the block imports this package.
package rws_pkg;

  localparam int DEF_MAX_POPULATION = 64;
  localparam int DEF_FITNESS_BITS   = 16;
  localparam int DEF_FRACTION_BITS  = 16;

  // Cumulative sums saturate at the top of this width
  localparam int              SUM_W   = 24;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam int                     DRAW_LIMIT_W     = 7;
  localparam logic [DRAW_LIMIT_W-1:0] DRAW_LIMIT_RESET = 7'd64;

  // Configuration port
  localparam int                  CFG_IDX_W        = 1;
  localparam int                  CFG_DATA_W       = DRAW_LIMIT_W;
  localparam logic [CFG_IDX_W-1:0] CFG_NATURAL_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAW_LIMIT   = 1'b1;

  // Item kinds on the input channel
  localparam int              KIND_W     = 2;
  localparam logic [KIND_W-1:0] KIND_FIRST = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MORE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd2;

  localparam int QUEUE_DEPTH = 2;

  // Commands passed from the front end to the back end
  typedef enum logic [1:0] {
    OP_RESTART,
    OP_LOAD,
    OP_DRAW
  } op_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### src/rws_stream_if.sv
// Valid/ready channel interfaces of the roulette wheel selector.
// Depends on rws_pkg for default widths and the kind width.
interface rws_in_if import rws_pkg::*; #(
  parameter int FITNESS_BITS  = DEF_FITNESS_BITS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
);
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [FITNESS_BITS-1:0]  fitness;
  logic [FRACTION_BITS-1:0] fraction;

  modport source (output valid, kind, fitness, fraction, input ready);
  modport sink   (input valid, kind, fitness, fraction, output ready);
endinterface

interface rws_out_if import rws_pkg::*; #(
  parameter int IDX_W = $clog2(DEF_MAX_POPULATION)
);
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] selected_index;
  logic             last_selection;

  modport source (output valid, selected_index, last_selection, input ready);
  modport sink   (input valid, selected_index, last_selection, output ready);
endinterface

### src/rws_front.sv
// Front end: accepts input items, classifies them into commands and holds
// the configuration registers. Depends on rws_pkg and rws_in_if.
module rws_front import rws_pkg::*; #(
  parameter int FITNESS_BITS  = DEF_FITNESS_BITS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS,
  localparam int ARG_W  = (FITNESS_BITS > FRACTION_BITS) ? FITNESS_BITS : FRACTION_BITS,
  localparam int DATA_W = ARG_W + 3
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  rws_in_if.sink                  in_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  q_stat_t                 q_stat_i,
  output logic                    q_push_o,
  output logic [DATA_W-1:0]       q_data_o,
  output logic [DRAW_LIMIT_W-1:0] draw_limit_o
);

  logic                    natural_q;
  logic [DRAW_LIMIT_W-1:0] draw_limit_q;
  logic                    accept;
  op_e                     op;
  logic                    keep;
  logic [ARG_W-1:0]        arg;

  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    op   = OP_LOAD;
    keep = 1'b1;
    arg  = ARG_W'(in_i.fitness);
    unique case (in_i.kind)
      KIND_FIRST: op = OP_RESTART;
      KIND_MORE:  op = OP_LOAD;
      KIND_DRAW: begin
        op  = OP_DRAW;
        arg = ARG_W'(in_i.fraction);
      end
      default: keep = 1'b0; // unused kind: drop
    endcase
  end

  assign q_push_o     = accept && keep;
  // Mode is sampled with the item so that it travels with the load
  assign q_data_o     = {op, natural_q, arg};
  assign draw_limit_o = draw_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      natural_q    <= 1'b1;
      draw_limit_q <= DRAW_LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NATURAL_MODE: natural_q    <= cfg_data_i[0];
        CFG_DRAW_LIMIT:   draw_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

### src/rws_queue.sv
// Short command queue between the front end and the back end.
// Depends on rws_pkg for the status struct.
module rws_queue import rws_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  input  logic              pop_i,
  output q_stat_t           stat_o,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push, do_pop;

  assign stat_o.full  = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = entries[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries[wr_ptr_q] <= data_i;
    end
  end

endmodule

### src/rws_recip.sv
// Restoring divider for the reciprocal 2^FITNESS_BITS / divisor,
// one quotient bit per cycle. Depends on rws_pkg for default widths.
module rws_recip import rws_pkg::*; #(
  parameter int FITNESS_BITS = DEF_FITNESS_BITS,
  localparam int STEPS = FITNESS_BITS + 1,
  localparam int CW    = $clog2(STEPS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [FITNESS_BITS-1:0] divisor_i,
  output logic                  done_o,
  output logic [FITNESS_BITS:0] quotient_o
);

  logic                    busy_q, done_q;
  logic [CW-1:0]           cnt_q;
  logic [FITNESS_BITS-1:0] div_q, rem_q;
  logic [FITNESS_BITS:0]   quo_q;
  logic                    bit_in, ge;
  logic [FITNESS_BITS:0]   trial, diff;

  // Dividend is a one followed by zeros: feed the one on the first step
  assign bit_in = (cnt_q == CW'(STEPS));
  assign trial  = {rem_q, bit_in};
  assign diff   = trial - {1'b0, div_q};
  assign ge     = (trial >= {1'b0, div_q});

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[FITNESS_BITS-1:0] : trial[FITNESS_BITS-1:0];
      quo_q <= {quo_q[FITNESS_BITS-1:0], ge};
    end
  end

endmodule

### src/rws_back.sv
// Back end: runs loads (reciprocal in inverse mode, cumulative sum) and draws (target,
// scan of the sums memory) and holds the result register.
// Depends on rws_pkg and rws_out_if.
module rws_back import rws_pkg::*; #(
  parameter int MAX_POPULATION = DEF_MAX_POPULATION,
  parameter int FITNESS_BITS   = DEF_FITNESS_BITS,
  parameter int FRACTION_BITS  = DEF_FRACTION_BITS,
  localparam int IDX_W  = $clog2(MAX_POPULATION),
  localparam int CNT_W  = $clog2(MAX_POPULATION + 1),
  localparam int ARG_W  = (FITNESS_BITS > FRACTION_BITS) ? FITNESS_BITS : FRACTION_BITS,
  localparam int DATA_W = ARG_W + 3
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  q_stat_t                 q_stat_i,
  input  logic [DATA_W-1:0]       q_data_i,
  output logic                    q_pop_o,
  input  logic [DRAW_LIMIT_W-1:0] draw_limit_i,
  output logic                    div_start_o,
  output logic [FITNESS_BITS-1:0] div_divisor_o,
  input  logic                    div_done_i,
  input  logic [FITNESS_BITS:0]   div_quotient_i,
  rws_out_if.source               out_o
);

  localparam int ADJ_W  = FITNESS_BITS + 1;
  localparam int SUMX_W = ((SUM_W > ADJ_W) ? SUM_W : ADJ_W) + 1;
  localparam int PROD_W = SUM_W + FRACTION_BITS + 1;
  localparam int LIM_W  = (CNT_W > DRAW_LIMIT_W) ? CNT_W : DRAW_LIMIT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_ADD,
    ST_MUL,
    ST_SCAN,
    ST_OUT
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             zero_q, zero_d;
  logic [IDX_W-1:0] fz_q, fz_d;
  logic [CNT_W-1:0] draws_q, draws_d;
  logic [SUM_W-1:0] total_q, total_d;
  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] out_idx_q, out_idx_d;
  logic             out_last_q, out_last_d;

  logic [ARG_W-1:0] arg_q, arg_d;
  logic             nat_q, nat_d;
  logic [ADJ_W-1:0] adj_q, adj_d;
  logic [SUM_W-1:0] target_q, target_d;
  logic [IDX_W-1:0] scan_q, scan_d;
  logic [IDX_W-1:0] sel_q, sel_d;

  logic [SUM_W-1:0] sums [MAX_POPULATION];
  logic [SUM_W-1:0] rd_data_q;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;

  op_e                     op;
  logic [FITNESS_BITS-1:0] fit;
  logic [FRACTION_BITS:0]  frac1;
  logic [PROD_W-1:0]       prod;
  logic [SUMX_W-1:0]       sum_full;
  logic [SUM_W-1:0]        sum_sat;
  logic [LIM_W-1:0]        limit_ext;
  logic [CNT_W-1:0]        limit;

  assign op       = op_e'(q_data_i[DATA_W-1 -: 2]);
  assign fit      = arg_q[FITNESS_BITS-1:0];
  assign frac1    = {1'b0, arg_q[FRACTION_BITS-1:0]} + (FRACTION_BITS + 1)'(1);
  assign prod     = PROD_W'(total_q) * PROD_W'(frac1);
  assign sum_full = SUMX_W'(total_q) + SUMX_W'(adj_q);
  assign sum_sat  = (sum_full > SUMX_W'(SUM_MAX)) ? SUM_MAX : sum_full[SUM_W-1:0];

  // Selection limit is the smaller of the register and the population
  assign limit_ext = (LIM_W'(draw_limit_i) < LIM_W'(cnt_q)) ? LIM_W'(draw_limit_i)
                                                            : LIM_W'(cnt_q);
  assign limit     = limit_ext[CNT_W-1:0];

  assign div_divisor_o        = fit;
  assign out_o.valid          = out_valid_q;
  assign out_o.selected_index = out_idx_q;
  assign out_o.last_selection = out_last_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    zero_d      = zero_q;
    fz_d        = fz_q;
    draws_d     = draws_q;
    total_d     = total_q;
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    arg_d       = arg_q;
    nat_d       = nat_q;
    adj_d       = adj_q;
    target_d    = target_q;
    scan_d      = scan_q;
    sel_d       = sel_q;
    rd_addr     = scan_q;
    mem_we      = 1'b0;
    q_pop_o     = 1'b0;
    div_start_o = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          q_pop_o = 1'b1;
          arg_d   = q_data_i[ARG_W-1:0];
          nat_d   = q_data_i[ARG_W];
          case (op)
            OP_RESTART: begin
              cnt_d   = '0;
              zero_d  = 1'b0;
              fz_d    = '0;
              draws_d = '0;
              total_d = '0;
              state_d = ST_LOAD;
            end
            OP_LOAD: state_d = ST_LOAD;
            OP_DRAW: begin
              // Drop draws past the limit, including on an empty table
              if (draws_q < limit) begin
                if (zero_q) begin
                  sel_d   = fz_q;
                  state_d = ST_OUT;
                end else begin
                  state_d = ST_MUL;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        if (cnt_q == CNT_W'(MAX_POPULATION)) begin
          state_d = ST_IDLE; // table full: drop
        end else if (nat_q) begin
          adj_d   = ADJ_W'(fit);
          state_d = ST_ADD;
        end else if (fit == '0) begin
          // Infinite weight: remember the first one, add nothing
          adj_d = '0;
          if (!zero_q) begin
            zero_d = 1'b1;
            fz_d   = cnt_q[IDX_W-1:0];
          end
          state_d = ST_ADD;
        end else begin
          div_start_o = 1'b1;
          state_d     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done_i) begin
          adj_d   = div_quotient_i;
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        mem_we  = 1'b1;
        total_d = sum_sat;
        cnt_d   = cnt_q + CNT_W'(1);
        state_d = ST_IDLE;
      end
      ST_MUL: begin
        target_d = prod[FRACTION_BITS +: SUM_W];
        scan_d   = '0;
        rd_addr  = '0;
        state_d  = ST_SCAN;
      end
      ST_SCAN: begin
        // Sums never decrease: stop at the first one not below the target, or at the last
        if ((CNT_W'(scan_q) == cnt_q - CNT_W'(1)) || (rd_data_q >= target_q)) begin
          sel_d   = scan_q;
          state_d = ST_OUT;
        end else begin
          scan_d  = scan_q + IDX_W'(1);
          rd_addr = scan_q + IDX_W'(1);
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_idx_d   = sel_q;
          out_last_d  = (draws_q + CNT_W'(1) == limit);
          draws_d     = draws_q + CNT_W'(1);
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      zero_q      <= 1'b0;
      fz_q        <= '0;
      draws_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      zero_q      <= zero_d;
      fz_q        <= fz_d;
      draws_q     <= draws_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      out_idx_q   <= out_idx_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    arg_q    <= arg_d;
    nat_q    <= nat_d;
    adj_q    <= adj_d;
    target_q <= target_d;
    scan_q   <= scan_d;
    sel_q    <= sel_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sums[cnt_q[IDX_W-1:0]] <= sum_sat;
    end
    rd_data_q <= sums[rd_addr];
  end

endmodule

### src/roulette_wheel_selector.sv
// Roulette wheel selector top level: front end, command queue, back end and
// reciprocal divider. Depends on rws_pkg, rws_stream_if and the modules it uses.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+-----------------------------------
//   in_i    | in  | valid/ready         | kind, fitness, fraction
//   out_o   | out | valid/ready         | selected_index, last_selection
//   cfg     | in  | cfg_we_i, no ready  | cfg_idx_i, cfg_data_i
//
// In the back end a natural-mode load passes LOAD and ADD; an inverse-mode load
// of nonzero fitness also waits in DIV on the divider, one quotient bit a cycle.
// A draw passes MUL, then SCAN (up to the population) at one read a cycle
// from the sums memory, then OUT; after an inverse-mode zero fitness, only OUT.
// Reset is asynchronous and clears the counters; the sums need no clearing.
// A stalled output holds its result while the two-entry queue keeps filling.
module roulette_wheel_selector import rws_pkg::*; #(
  parameter int MAX_POPULATION = DEF_MAX_POPULATION,
  parameter int FITNESS_BITS   = DEF_FITNESS_BITS,
  parameter int FRACTION_BITS  = DEF_FRACTION_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rws_in_if.sink                in_i,
  rws_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int ARG_W  = (FITNESS_BITS > FRACTION_BITS) ? FITNESS_BITS : FRACTION_BITS;
  localparam int DATA_W = ARG_W + 3;

  q_stat_t                 q_stat;
  logic                    q_push, q_pop;
  logic [DATA_W-1:0]       q_wdata, q_rdata;
  logic [DRAW_LIMIT_W-1:0] draw_limit;
  logic                    div_start, div_done;
  logic [FITNESS_BITS-1:0] div_divisor;
  logic [FITNESS_BITS:0]   div_quotient;

  rws_front #(
    .FITNESS_BITS  (FITNESS_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .q_stat_i     (q_stat),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata),
    .draw_limit_o (draw_limit)
  );

  rws_queue #(
    .DATA_W (DATA_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .stat_o (q_stat),
    .data_o (q_rdata)
  );

  rws_recip #(
    .FITNESS_BITS (FITNESS_BITS)
  ) u_recip (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  rws_back #(
    .MAX_POPULATION (MAX_POPULATION),
    .FITNESS_BITS   (FITNESS_BITS),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_stat_i       (q_stat),
    .q_data_i       (q_rdata),
    .q_pop_o        (q_pop),
    .draw_limit_i   (draw_limit),
    .div_start_o    (div_start),
    .div_divisor_o  (div_divisor),
    .div_done_i     (div_done),
    .div_quotient_i (div_quotient),
    .out_o          (out_o)
  );

endmodule

### src/rws_checker.sv
// Port-level checks of the roulette wheel selector, bound to the top level.
// Depends on rws_pkg for the draw kind code.
module rws_checker import rws_pkg::*; #(
  parameter int IDX_W = $clog2(DEF_MAX_POPULATION)
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic [KIND_W-1:0] in_kind_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [IDX_W-1:0]  out_index_i,
  input logic              out_last_i
);

  localparam int PEND_W = 16;

  logic [PEND_W-1:0] pend_q;
  logic              draw_in, res_out;

  assign draw_in = in_valid_i && in_ready_i && (in_kind_i == KIND_DRAW);
  assign res_out = out_valid_i && out_ready_i;

  // Count draws not yet answered; dropped draws keep it high, which is safe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (draw_in && !res_out && (pend_q != {PEND_W{1'b1}})) begin
      pend_q <= pend_q + PEND_W'(1);
    end else if (res_out && !draw_in && (pend_q != '0)) begin
      pend_q <= pend_q - PEND_W'(1);
    end
  end

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result shown during reset");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pend_q != '0))
    else $error("result without an outstanding draw");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_index_i) && $stable(out_last_i))
    else $error("result changed while stalled");

endmodule

bind roulette_wheel_selector rws_checker #(
  .IDX_W ($clog2(MAX_POPULATION))
) u_rws_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_kind_i   (in_i.kind),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_index_i (out_o.selected_index),
  .out_last_i  (out_o.last_selection)
);
